[hw/rtl/brbs_pkg.sv]
// Shared types and constants of the byte range block splitter.
package brbs_pkg;

	// Fixed field widths
	localparam int OFF_W = 40;
	// Offset plus count, and device size in bytes, at full width
	localparam int SUM_W = 45;

	// Command kinds
	localparam logic [2:0] KIND_PART_READ    = 3'd0;
	localparam logic [2:0] KIND_PART_RMW     = 3'd1;
	localparam logic [2:0] KIND_DIRECT_READ  = 3'd2;
	localparam logic [2:0] KIND_DIRECT_WRITE = 3'd3;
	localparam logic [2:0] KIND_REJECT       = 3'd4;

	// Configuration register indexes
	localparam logic REG_BLOCK_SHIFT  = 1'b0;
	localparam logic REG_TOTAL_BLOCKS = 1'b1;

	// Request beat
	typedef struct packed {
		logic             op;
		logic [OFF_W-1:0] byte_offset;
		logic [31:0]      byte_count;
	} req_t;

	// Command beat
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] block_index;
		logic [23:0] block_count;
		logic [11:0] in_block_offset;
		logic [31:0] segment_length;
		logic [31:0] buffer_offset;
		logic [31:0] accepted_bytes;
		logic        last;
	} res_t;

	// Classified request, passed from front end to back end
	typedef struct packed {
		logic        rej;
		logic        op;
		logic        has_head;
		logic        has_mid;
		logic        has_tail;
		logic [31:0] blk0;
		logic [11:0] lo;
		logic [12:0] headlen;
		logic [23:0] midcnt;
		logic [31:0] midlen;
		logic [11:0] taillen;
		logic [31:0] total;
	} plan_t;

endpackage

[hw/rtl/brbs_front.sv]
// Front end: takes requests, checks range, classifies head, middle and tail.
module brbs_front #(
	parameter int BYTE_ADDR_BITS = 40,
	parameter int DEPTH = 4,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  brbs_pkg::req_t  req,
	input  logic [3:0]      block_shift,
	input  logic [31:0]     total_blocks,
	input  logic [CW-1:0]   q_count,
	output logic            push,
	output brbs_pkg::plan_t plan
);
	import brbs_pkg::*;

	// Block mask for a shift code (0 means 512 bytes ... 3 means 4096 bytes)
	function automatic logic [11:0] blk_mask(input logic [1:0] sel);
		logic [11:0] m;
		unique case (sel)
			2'd0: m = 12'h1FF;
			2'd1: m = 12'h3FF;
			2'd2: m = 12'h7FF;
			default: m = 12'hFFF;
		endcase
		return m;
	endfunction

	logic             accept;
	logic [OFF_W-1:0] off_m;
	logic [1:0]       sel_d;
	logic [SUM_W-1:0] off_x;
	logic [SUM_W-1:0] end_x;
	logic [SUM_W-1:0] dev_x;
	logic             rej_d;
	logic [31:0]      blk0_d;
	logic [11:0]      lo_d;

	logic        valid_s1;
	logic        op_s1;
	logic        rej_s1;
	logic [1:0]  sel_s1;
	logic [31:0] blk0_s1;
	logic [11:0] lo_s1;
	logic [31:0] size_s1;

	logic [11:0] bmask;
	logic [12:0] bs;
	logic [12:0] room;
	logic        has_head;
	logic [12:0] headlen;
	logic [31:0] size2;
	logic [23:0] midcnt;
	logic [31:0] midlen;
	logic [11:0] taillen;

	// Hold off a new request unless the queue has room for it and the one in flight
	assign busy   = ({1'b0, q_count} + {{CW{1'b0}}, valid_s1}) >= (CW + 1)'(DEPTH);
	assign accept = start && !busy;

	// Drop offset bits above the address width
	always_comb begin
		for (int i = 0; i < OFF_W; i++) begin
			off_m[i] = (i < BYTE_ADDR_BITS) ? req.byte_offset[i] : 1'b0;
		end
	end

	// Saturate the block shift to 9..12
	always_comb begin
		priority if (block_shift < 4'd9) begin
			sel_d = 2'd0;
		end else if (block_shift > 4'd12) begin
			sel_d = 2'd3;
		end else begin
			sel_d = 2'(block_shift - 4'd9);
		end
	end

	// Range check at full width, first block and offset inside it
	always_comb begin
		off_x = SUM_W'(off_m);
		end_x = off_x + SUM_W'(req.byte_count);
		unique case (sel_d)
			2'd0: begin
				dev_x  = {4'b0, total_blocks, 9'b0};
				blk0_d = off_x[40:9];
			end
			2'd1: begin
				dev_x  = {3'b0, total_blocks, 10'b0};
				blk0_d = off_x[41:10];
			end
			2'd2: begin
				dev_x  = {2'b0, total_blocks, 11'b0};
				blk0_d = off_x[42:11];
			end
			default: begin
				dev_x  = {1'b0, total_blocks, 12'b0};
				blk0_d = off_x[43:12];
			end
		endcase
		rej_d = (req.byte_count == 32'd0) || (end_x > dev_x);
		lo_d  = off_m[11:0] & blk_mask(sel_d);
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= req.op;
			rej_s1  <= rej_d;
			sel_s1  <= sel_d;
			blk0_s1 <= blk0_d;
			lo_s1   <= lo_d;
			size_s1 <= req.byte_count;
		end
	end

	// Split into head, aligned middle and tail
	always_comb begin
		bmask    = blk_mask(sel_s1);
		bs       = {1'b0, bmask} + 13'd1;
		room     = bs - {1'b0, lo_s1};
		has_head = (lo_s1 != 12'd0);
		if (!has_head) begin
			headlen = 13'd0;
		end else if (size_s1 < {19'b0, room}) begin
			headlen = size_s1[12:0];
		end else begin
			headlen = room;
		end
		size2 = size_s1 - {19'b0, headlen};
		unique case (sel_s1)
			2'd0: midcnt = {1'b0, size2[31:9]};
			2'd1: midcnt = {2'b0, size2[31:10]};
			2'd2: midcnt = {3'b0, size2[31:11]};
			default: midcnt = {4'b0, size2[31:12]};
		endcase
		midlen  = size2 & ~{20'b0, bmask};
		taillen = size2[11:0] & bmask;
	end

	// Hand the classified request to the queue
	always_comb begin
		push          = valid_s1;
		plan.rej      = rej_s1;
		plan.op       = op_s1;
		plan.has_head = has_head;
		plan.has_mid  = (midcnt != 24'd0);
		plan.has_tail = (taillen != 12'd0);
		plan.blk0     = blk0_s1;
		plan.lo       = lo_s1;
		plan.headlen  = headlen;
		plan.midcnt   = midcnt;
		plan.midlen   = midlen;
		plan.taillen  = taillen;
		plan.total    = size_s1;
	end

endmodule

[hw/rtl/brbs_queue.sv]
// Short queue of classified requests between front end and back end.
module brbs_queue #(
	parameter int DEPTH = 4,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  brbs_pkg::plan_t wdata,
	input  logic            pop,
	output brbs_pkg::plan_t rdata,
	output logic            empty,
	output logic [CW-1:0]   count
);
	import brbs_pkg::*;

	plan_t         entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign rdata = entry_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[hw/rtl/brbs_back.sv]
// Back end: issues the block commands of each request, one per cycle.
module brbs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  brbs_pkg::plan_t head,
	output logic            pop,
	output logic            done,
	output brbs_pkg::res_t  result
);
	import brbs_pkg::*;

	logic       active_q;
	logic [2:0] pend_q;
	plan_t      cur_q;
	logic       done_q;
	res_t       res_q;

	plan_t       cur;
	logic [2:0]  pend;
	logic [2:0]  rest;
	logic        go;
	logic [2:0]  part_kind;
	logic [2:0]  direct_kind;
	logic [31:0] mid_blk;
	logic [31:0] tail_blk;
	logic [31:0] tail_buf;
	res_t        res_d;

	// Pick the next command of the current request
	always_comb begin
		cur  = active_q ? cur_q : head;
		pend = active_q ? pend_q
			: (head.rej ? 3'b001 : {head.has_tail, head.has_mid, head.has_head});
		go   = active_q || !q_empty;
		pop  = !active_q && !q_empty;

		part_kind   = cur.op ? KIND_PART_RMW : KIND_PART_READ;
		direct_kind = cur.op ? KIND_DIRECT_WRITE : KIND_DIRECT_READ;
		mid_blk     = cur.blk0 + {31'b0, cur.has_head};
		tail_blk    = mid_blk + {8'b0, cur.midcnt};
		tail_buf    = {19'b0, cur.headlen} + cur.midlen;

		res_d = '0;
		res_d.accepted_bytes = cur.total;
		priority if (pend[0]) begin
			rest                  = pend & 3'b110;
			res_d.kind            = part_kind;
			res_d.block_index     = cur.blk0;
			res_d.block_count     = 24'd1;
			res_d.in_block_offset = cur.lo;
			res_d.segment_length  = {19'b0, cur.headlen};
		end else if (pend[1]) begin
			rest                  = pend & 3'b100;
			res_d.kind            = direct_kind;
			res_d.block_index     = mid_blk;
			res_d.block_count     = cur.midcnt;
			res_d.segment_length  = cur.midlen;
			res_d.buffer_offset   = {19'b0, cur.headlen};
		end else begin
			rest                  = 3'b000;
			res_d.kind            = part_kind;
			res_d.block_index     = tail_blk;
			res_d.block_count     = 24'd1;
			res_d.segment_length  = {20'b0, cur.taillen};
			res_d.buffer_offset   = tail_buf;
		end
		// Rejected request: one command with last set, all other fields zero
		if (cur.rej) begin
			res_d      = '0;
			res_d.kind = KIND_REJECT;
		end
		res_d.last = (rest == 3'b000);
	end

	// Control: track remaining commands and the output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pend_q   <= 3'b000;
			done_q   <= 1'b0;
		end else begin
			done_q <= go;
			if (go) begin
				active_q <= (rest != 3'b000);
				pend_q   <= rest;
			end
		end
	end

	// Payload: current request and output beat
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (go) begin
			res_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

[hw/rtl/byte_range_block_splitter_core.sv]
// Byte range block splitter: top level with configuration registers.
//
// A request (op, byte_offset, byte_count) is taken at a clock edge where start is high and
// busy is low. It becomes one to three block commands (unaligned head, aligned middle,
// tail), or one rejected command when the size is zero or the range runs past the end of
// the device. Each command is shown on result for exactly one cycle with done high; the
// receiver cannot stall, so it must take every beat. The first command of a request passes
// the range check stage, then the queue, then the registered command issue before it is on
// result. The back end issues one command per cycle, so a request occupies it until all of
// its commands (1 to 3) are out, and only then is the next request taken from the queue. A
// four-entry queue between the range check and the command issue absorbs bursts; busy
// rises once the queued requests plus the one in the check stage reach the queue depth.
// The user must write configuration through cfg_we, cfg_index and cfg_wdata only while
// idle; the block itself does not enforce this.
module byte_range_block_splitter_core #(
	parameter int BYTE_ADDR_BITS = 40,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  brbs_pkg::req_t req,
	output logic           done,
	output brbs_pkg::res_t result,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [31:0]    cfg_wdata
);
	import brbs_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [3:0]    block_shift_q;
	logic [31:0]   total_blocks_q;
	logic          push;
	logic          pop;
	logic          q_empty;
	logic [CW-1:0] q_count;
	plan_t         plan_in;
	plan_t         plan_out;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_shift_q  <= 4'd9;
			total_blocks_q <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCK_SHIFT:  block_shift_q  <= cfg_wdata[3:0];
				REG_TOTAL_BLOCKS: total_blocks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	brbs_front #(
		.BYTE_ADDR_BITS(BYTE_ADDR_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.block_shift(block_shift_q),
		.total_blocks(total_blocks_q),
		.q_count(q_count),
		.push(push),
		.plan(plan_in)
	);

	brbs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(plan_in),
		.pop(pop),
		.rdata(plan_out),
		.empty(q_empty),
		.count(q_count)
	);

	brbs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.head(plan_out),
		.pop(pop),
		.done(done),
		.result(result)
	);

endmodule
